FILE: hw/rtl/ttm_pkg.sv
package ttm_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;

    localparam int ID_W      = 16;
    localparam int CONF_W    = 8;
    localparam int QUAL_W    = 4;
    localparam int TYPE_W    = 4;
    localparam int SENS_W    = 8;
    localparam int FLAG_W    = 4;
    localparam int KIN_W     = 64;
    localparam int AGE_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 5;
    localparam int PURGE_W   = 6;

    localparam logic [AGE_W-1:0]  MAX_AGE_RESET = 16'd5000;
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN  = 4'd0;

    localparam logic KIND_MERGE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MERGED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_AGED     = 2'd3;

    // One table entry as held in the track memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CONF_W-1:0] conf;
        logic [QUAL_W-1:0] qual;
        logic [TYPE_W-1:0] typ;
        logic [SENS_W-1:0] sens;
        logic [FLAG_W-1:0] flags;
        logic [KIN_W-1:0]  kin;
        logic [AGE_W-1:0]  age;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic out_load;
    } ttm_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_last;
        logic tick;
        logic out_free;
    } ttm_sts_t;

endpackage

FILE: hw/rtl/ttm_ram.sv
module ttm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ttm_ctrl.sv
module ttm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ttm_pkg::ttm_sts_t sts,
    output ttm_pkg::ttm_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                // A merge stops at the first matching entry.
                if (sts.hit)
                begin
                    state_next = S_WRITE;
                end
                else if (sts.scan_last)
                begin
                    state_next = sts.tick ? S_DONE : S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_write_follows_merge: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> !sts.tick)
        else $error("table write-back issued for an age tick");

    a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> (state_reg == S_DONE))
        else $error("write-back not followed by result stage");

    a_load_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.scan)
        else $error("accepted word not followed by a table scan");

endmodule

FILE: hw/rtl/ttm_dp.sv
module ttm_dp #(
    parameter int TABLE_ENTRIES = ttm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ttm_pkg::ttm_cmd_t             cmd,
    output ttm_pkg::ttm_sts_t             sts,
    input  logic                          kind,
    input  logic [ttm_pkg::ID_W-1:0]      entity_id,
    input  logic [ttm_pkg::CONF_W-1:0]    confidence,
    input  logic [ttm_pkg::QUAL_W-1:0]    quality,
    input  logic [ttm_pkg::TYPE_W-1:0]    contact_type,
    input  logic [ttm_pkg::SENS_W-1:0]    sensor_mask,
    input  logic [ttm_pkg::FLAG_W-1:0]    flag_bits,
    input  logic [ttm_pkg::KIN_W-1:0]     kinematics,
    input  logic [ttm_pkg::AGE_W-1:0]     elapsed,
    input  logic                          max_age_we,
    input  logic [ttm_pkg::AGE_W-1:0]     max_age_wdata,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [ttm_pkg::STATUS_W-1:0]  status,
    output logic [ttm_pkg::SLOT_W-1:0]    slot,
    output logic [ttm_pkg::PURGE_W-1:0]   purged_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int AGE_W = ttm_pkg::AGE_W;

    // Held copy of the accepted word.
    logic                          kind_reg;
    logic [ttm_pkg::ID_W-1:0]      id_reg;
    logic [ttm_pkg::CONF_W-1:0]    conf_reg;
    logic [ttm_pkg::QUAL_W-1:0]    qual_reg;
    logic [ttm_pkg::TYPE_W-1:0]    typ_reg;
    logic [ttm_pkg::SENS_W-1:0]    sens_reg;
    logic [ttm_pkg::FLAG_W-1:0]    flag_reg;
    logic [ttm_pkg::KIN_W-1:0]     kin_reg;
    logic [AGE_W-1:0]              elapsed_reg;

    logic [AGE_W-1:0]              max_age_reg;
    logic [TABLE_ENTRIES-1:0]      valid_reg;
    logic [TABLE_ENTRIES-1:0]      valid_next;
    logic [CNT_W-1:0]              rd_cnt_reg;
    logic                          cmp_vld_reg;
    logic [IDX_W-1:0]              cmp_idx_reg;
    logic                          hit_reg;
    logic [IDX_W-1:0]              hit_slot_reg;
    logic                          have_free_reg;
    logic [IDX_W-1:0]              free_slot_reg;
    logic [CNT_W-1:0]              purged_cnt_reg;
    ttm_pkg::entry_t               merged_reg;

    logic                          out_valid_reg;
    logic [ttm_pkg::STATUS_W-1:0]  status_reg;
    logic [ttm_pkg::SLOT_W-1:0]    slot_reg;
    logic [ttm_pkg::PURGE_W-1:0]   purged_reg;

    ttm_pkg::entry_t               rdata;
    ttm_pkg::entry_t               wdata;
    ttm_pkg::entry_t               new_word;
    ttm_pkg::entry_t               merged_word;
    ttm_pkg::entry_t               aged_word;
    logic                          we;
    logic [IDX_W-1:0]              waddr;
    logic                          issue_en;
    logic                          cur_valid;
    logic                          id_hit;
    logic                          free_now;
    logic                          tick_we;
    logic                          purge_now;
    logic                          insert_now;
    logic [AGE_W:0]                age_sum;
    logic [AGE_W-1:0]              age_sat;
    logic [IDX_W-1:0]              res_slot;
    logic [ttm_pkg::SLOT_W-1:0]    res_slot_ext;
    logic [ttm_pkg::PURGE_W-1:0]   purged_ext;
    logic [ttm_pkg::STATUS_W-1:0]  res_status;

    ttm_ram #(
        .WIDTH ($bits(ttm_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        issue_en  = cmd.scan && (rd_cnt_reg < CNT_W'(TABLE_ENTRIES));
        cur_valid = valid_reg[cmp_idx_reg];
        id_hit    = cmd.scan && (kind_reg == ttm_pkg::KIND_MERGE) && cmp_vld_reg
                    && cur_valid && (rdata.id == id_reg);
        free_now  = cmd.scan && (kind_reg == ttm_pkg::KIND_MERGE) && cmp_vld_reg
                    && !cur_valid && !have_free_reg;

        age_sum   = {1'b0, rdata.age} + {1'b0, elapsed_reg};
        age_sat   = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
        tick_we   = cmd.scan && (kind_reg == ttm_pkg::KIND_TICK) && cmp_vld_reg && cur_valid;
        purge_now = tick_we && (age_sat > max_age_reg);
        insert_now = cmd.write && !hit_reg && have_free_reg;

        aged_word     = rdata;
        aged_word.age = age_sat;

        // Refresh of a matched entry; the payload follows the better confidence.
        merged_word = rdata;
        if (conf_reg >= rdata.conf)
        begin
            merged_word.kin  = kin_reg;
            merged_word.conf = conf_reg;
        end
        merged_word.sens  = rdata.sens | sens_reg;
        merged_word.flags = rdata.flags | flag_reg;
        if (qual_reg > rdata.qual)
        begin
            merged_word.qual = qual_reg;
        end
        if ((typ_reg != ttm_pkg::TYPE_UNKNOWN) && (rdata.typ == ttm_pkg::TYPE_UNKNOWN))
        begin
            merged_word.typ = typ_reg;
        end
        merged_word.age = '0;

        new_word.id    = id_reg;
        new_word.conf  = conf_reg;
        new_word.qual  = qual_reg;
        new_word.typ   = typ_reg;
        new_word.sens  = sens_reg;
        new_word.flags = flag_reg;
        new_word.kin   = kin_reg;
        new_word.age   = '0;

        we = tick_we || (cmd.write && (hit_reg || have_free_reg));
        if (cmd.write)
        begin
            waddr = hit_reg ? hit_slot_reg : free_slot_reg;
            wdata = hit_reg ? merged_reg : new_word;
        end
        else
        begin
            waddr = cmp_idx_reg;
            wdata = aged_word;
        end

        valid_next = valid_reg;
        if (purge_now)
        begin
            valid_next[cmp_idx_reg] = 1'b0;
        end
        if (insert_now)
        begin
            valid_next[free_slot_reg] = 1'b1;
        end

        if (kind_reg == ttm_pkg::KIND_TICK)
        begin
            res_status = ttm_pkg::ST_AGED;
        end
        else if (hit_reg)
        begin
            res_status = ttm_pkg::ST_MERGED;
        end
        else if (have_free_reg)
        begin
            res_status = ttm_pkg::ST_INSERTED;
        end
        else
        begin
            res_status = ttm_pkg::ST_DROPPED;
        end
        res_slot = hit_reg ? hit_slot_reg : free_slot_reg;
    end

    // Slot and purge count are cut or zero-padded to the width of the result fields.
    if (IDX_W >= ttm_pkg::SLOT_W)
    begin : g_slot_cut
        assign res_slot_ext = res_slot[ttm_pkg::SLOT_W-1:0];
    end
    else
    begin : g_slot_pad
        assign res_slot_ext = {{(ttm_pkg::SLOT_W - IDX_W){1'b0}}, res_slot};
    end

    if (CNT_W >= ttm_pkg::PURGE_W)
    begin : g_purge_cut
        assign purged_ext = purged_cnt_reg[ttm_pkg::PURGE_W-1:0];
    end
    else
    begin : g_purge_pad
        assign purged_ext = {{(ttm_pkg::PURGE_W - CNT_W){1'b0}}, purged_cnt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg    <= ttm_pkg::MAX_AGE_RESET;
            valid_reg      <= '0;
            rd_cnt_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            have_free_reg  <= 1'b0;
            purged_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (max_age_we)
            begin
                max_age_reg <= max_age_wdata;
            end
            valid_reg <= valid_next;
            if (cmd.load)
            begin
                rd_cnt_reg     <= '0;
                cmp_vld_reg    <= 1'b0;
                hit_reg        <= 1'b0;
                have_free_reg  <= 1'b0;
                purged_cnt_reg <= '0;
            end
            else
            begin
                if (issue_en)
                begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
                cmp_vld_reg <= issue_en;
                if (id_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_now)
                begin
                    have_free_reg <= 1'b1;
                end
                if (purge_now)
                begin
                    purged_cnt_reg <= purged_cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            id_reg      <= entity_id;
            conf_reg    <= confidence;
            qual_reg    <= quality;
            typ_reg     <= contact_type;
            sens_reg    <= sensor_mask;
            flag_reg    <= flag_bits;
            kin_reg     <= kinematics;
            elapsed_reg <= elapsed;
        end
        if (issue_en)
        begin
            cmp_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        end
        if (id_hit)
        begin
            hit_slot_reg <= cmp_idx_reg;
            merged_reg   <= merged_word;
        end
        if (free_now)
        begin
            free_slot_reg <= cmp_idx_reg;
        end
        if (cmd.out_load)
        begin
            status_reg <= res_status;
            if ((res_status == ttm_pkg::ST_MERGED) || (res_status == ttm_pkg::ST_INSERTED))
            begin
                slot_reg <= res_slot_ext;
            end
            else
            begin
                slot_reg <= '0;
            end
            purged_reg <= (kind_reg == ttm_pkg::KIND_TICK) ? purged_ext : '0;
        end
    end

    assign sts.hit       = id_hit;
    assign sts.scan_last = cmp_vld_reg && (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign sts.tick      = (kind_reg == ttm_pkg::KIND_TICK);
    assign sts.out_free  = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign purged_count = purged_reg;

    a_we_source: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((cmd.scan && (kind_reg == ttm_pkg::KIND_TICK)) || cmd.write))
        else $error("table written outside an age sweep or write-back");

    a_hit_only_merge: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (kind_reg == ttm_pkg::KIND_MERGE))
        else $error("match recorded during an age tick");

    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        insert_now |=> valid_reg[free_slot_reg])
        else $error("inserted entry not marked valid");

    a_purge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        purged_cnt_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("purge count above table size");

endmodule

FILE: hw/rtl/track_table_merge_and_age_unit.sv
// Track table with contact merge and age sweep.
// Words arrive on the item channel (item_valid / item_ready) and each one
// gives exactly one word on the result channel (result_valid / result_ready).
// kind 0 merges a contact into the entry with the same entity_id, or
// inserts it into the lowest free slot, or drops it when the table is full.
// kind 1 adds elapsed to the age of every valid entry, saturating, and
// purges entries older than max_age; purged_count reports how many.
// One word at a time: each is scanned through the track memory, one entry
// per cycle with a registered read. A merge stops the scan at its matching
// entry; an unmatched merge and a tick scan every entry. After the scan a
// merge writes its entry back (unless dropped) and a tick does not; then the
// result is loaded and the next word is accepted in the cycle after that.
// The result sits in an output register; the next word is accepted while
// it waits, but its own result is held back until the receiver takes the
// earlier one, so a stalled receiver stalls the item channel after one word.
// Reset clears all valid bits and sets max_age to 5000; no clearing pass over
// the memory is needed. max_age is written through max_age_we and max_age_wdata;
// the user does so only while the block is idle, which the block does not enforce.
module track_table_merge_and_age_unit #(
    parameter int TABLE_ENTRIES = ttm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          kind,
    input  logic [ttm_pkg::ID_W-1:0]      entity_id,
    input  logic [ttm_pkg::CONF_W-1:0]    confidence,
    input  logic [ttm_pkg::QUAL_W-1:0]    quality,
    input  logic [ttm_pkg::TYPE_W-1:0]    contact_type,
    input  logic [ttm_pkg::SENS_W-1:0]    sensor_mask,
    input  logic [ttm_pkg::FLAG_W-1:0]    flag_bits,
    input  logic [ttm_pkg::KIN_W-1:0]     kinematics,
    input  logic [ttm_pkg::AGE_W-1:0]     elapsed,
    input  logic                          max_age_we,
    input  logic [ttm_pkg::AGE_W-1:0]     max_age_wdata,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [ttm_pkg::STATUS_W-1:0]  status,
    output logic [ttm_pkg::SLOT_W-1:0]    slot,
    output logic [ttm_pkg::PURGE_W-1:0]   purged_count
);

    ttm_pkg::ttm_cmd_t cmd;
    ttm_pkg::ttm_sts_t sts;

    ttm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ttm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .entity_id     (entity_id),
        .confidence    (confidence),
        .quality       (quality),
        .contact_type  (contact_type),
        .sensor_mask   (sensor_mask),
        .flag_bits     (flag_bits),
        .kinematics    (kinematics),
        .elapsed       (elapsed),
        .max_age_we    (max_age_we),
        .max_age_wdata (max_age_wdata),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .status        (status),
        .slot          (slot),
        .purged_count  (purged_count)
    );

endmodule
